[rtl/periodic_poll_scheduler_assert.svh]
// Assertion macros, clocked on clk_i and disabled during rst_ni low
`ifndef PERIODIC_POLL_SCHEDULER_ASSERT_SVH
`define PERIODIC_POLL_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define PPS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PPS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pps_pkg.sv]
package pps_pkg;

  localparam int TIME_BITS    = 32;
  localparam int COUNT_BITS   = 32;
  localparam int IV_BITS      = 16;
  localparam int FAIL_BITS    = 8;
  localparam int CMD_BITS     = 3;
  localparam int CFG_IDX_BITS = 2;
  localparam int DIV_STEPS    = TIME_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

  localparam logic [IV_BITS-1:0] ACTIVE_RESET = IV_BITS'(1000);
  localparam logic [IV_BITS-1:0] IDLE_RESET   = IV_BITS'(5000);
  localparam logic [IV_BITS-1:0] WINDOW_RESET = IV_BITS'(15000);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_TICK        = 3'd0,
    CMD_DEMAND      = 3'd1,
    CMD_POLL_DONE   = 3'd2,
    CMD_RESET_SCHED = 3'd3,
    CMD_RESET_FAIL  = 3'd4
  } cmd_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ACTIVE = 2'd0,
    CFG_IDLE   = 2'd1,
    CFG_WINDOW = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CMD_BITS-1:0]  command;
    logic [TIME_BITS-1:0] now_ms;
    logic                 time_valid;
    logic                 client_connected;
    logic                 mount_busy;
    logic                 poll_blocked;
    logic                 position_valid;
    logic                 poll_ok;
  } pps_in_t;

  typedef struct packed {
    logic                  start_poll;
    logic [TIME_BITS-1:0]  latency_ms;
    logic [TIME_BITS-1:0]  next_due_ms;
    logic [COUNT_BITS-1:0] started_total;
    logic [COUNT_BITS-1:0] deferred_total;
    logic [COUNT_BITS-1:0] missed_total;
    logic [COUNT_BITS-1:0] succeeded_total;
    logic [TIME_BITS-1:0]  worst_latency_ms;
    logic [FAIL_BITS-1:0]  failures_in_row;
    logic [TIME_BITS-1:0]  first_success_ms;
    logic [TIME_BITS-1:0]  last_success_ms;
    logic [IV_BITS-1:0]    interval_used_ms;
  } pps_out_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic div_step;
    logic div_apply;
    logic publish;
  } pps_cmd_t;

  typedef struct packed {
    logic need_div;
  } pps_sts_t;

endpackage

[rtl/pps_if.sv]
interface pps_in_if;
  logic             valid;
  logic             ready;
  pps_pkg::pps_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pps_out_if;
  logic              valid;
  logic              ready;
  pps_pkg::pps_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/periodic_poll_scheduler.sv]
// Channel   Dir  Payload                 Transfer
// in_i      in   pps_in_t (8 fields)     valid & ready
// out_o     out  pps_out_t (12 fields)   valid & ready
// cfg       in   16-bit data, 2-bit idx  cfg_we_i
//
// Each item is executed, then published while the next is taken.
// A poll done that needs catch-up runs extra states: a 32-step radix-2
// divider finds the skipped slots, then an apply state applies the result.
// Reset is immediate: counters, schedule, config and FSM load at rst_ni low.
// A held result stalls intake only once the next result is ready to publish.
module periodic_poll_scheduler (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pps_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [pps_pkg::IV_BITS-1:0]      cfg_data_i,
  pps_in_if.sink                           in_i,
  pps_out_if.source                        out_o
);
  import pps_pkg::*;

  pps_cmd_t cmd;
  pps_sts_t sts;
  logic     in_ready;
  logic     out_valid;
  pps_out_t out_data;

  pps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pps_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_i.data),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

endmodule

[rtl/pps_datapath.sv]
module pps_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pps_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [pps_pkg::IV_BITS-1:0]          cfg_data_i,
  input  pps_pkg::pps_in_t                     in_data_i,
  input  pps_pkg::pps_cmd_t                    cmd_i,
  output pps_pkg::pps_sts_t                    sts_o,
  output pps_pkg::pps_out_t                    out_data_o
);
  import pps_pkg::*;

  logic [IV_BITS-1:0]    act_q, idle_q, win_q;
  logic [TIME_BITS-1:0]  ldt_q, ldt_d;
  logic [TIME_BITS-1:0]  nd_q, nd_d;
  logic                  outst_q, outst_d;
  logic [IV_BITS-1:0]    oiv_q, oiv_d;
  logic [COUNT_BITS-1:0] started_q, started_d;
  logic [COUNT_BITS-1:0] deferred_q, deferred_d;
  logic [COUNT_BITS-1:0] missed_q, missed_d;
  logic [COUNT_BITS-1:0] succ_q, succ_d;
  logic [TIME_BITS-1:0]  maxlat_q, maxlat_d;
  logic [FAIL_BITS-1:0]  fail_q, fail_d;
  logic [TIME_BITS-1:0]  first_q, first_d;
  logic [TIME_BITS-1:0]  last_q, last_d;

  pps_in_t               in_q;
  logic                  start_q, start_d;
  logic [TIME_BITS-1:0]  lat_q, lat_d;
  logic [TIME_BITS-1:0]  dvd_q, dvd_d;
  logic [IV_BITS-1:0]    rem_q, rem_d;
  pps_out_t              out_q;

  logic [TIME_BITS-1:0]  since_demand;
  logic                  active;
  logic [IV_BITS-1:0]    iv;
  logic [TIME_BITS-1:0]  due_diff;
  logic [TIME_BITS-1:0]  nd_adv;
  logic [TIME_BITS-1:0]  cu_diff;
  logic                  need_div;
  logic [IV_BITS:0]      trial;
  logic [IV_BITS:0]      trial_sub;
  logic                  trial_ge;

  // interval selection
  assign since_demand = in_q.now_ms - ldt_q;
  assign active = ((ldt_q != '0) && (since_demand < TIME_BITS'(win_q)))
                  || in_q.client_connected;
  assign iv = !in_q.time_valid ? '0 : (active ? act_q : idle_q);

  assign due_diff = in_q.now_ms - nd_q;
  assign nd_adv   = nd_q + TIME_BITS'(oiv_q);
  assign cu_diff  = in_q.now_ms - nd_adv;
  assign need_div = (in_q.command == CMD_POLL_DONE) && outst_q && (oiv_q != '0)
                    && !cu_diff[TIME_BITS-1];
  assign sts_o.need_div = need_div;

  // one restoring division step
  assign trial     = {rem_q, dvd_q[TIME_BITS-1]};
  assign trial_sub = trial - {1'b0, oiv_q};
  assign trial_ge  = !trial_sub[IV_BITS] || (trial >= {1'b0, oiv_q});

  always_comb begin
    ldt_d      = ldt_q;
    nd_d       = nd_q;
    outst_d    = outst_q;
    oiv_d      = oiv_q;
    started_d  = started_q;
    deferred_d = deferred_q;
    missed_d   = missed_q;
    succ_d     = succ_q;
    maxlat_d   = maxlat_q;
    fail_d     = fail_q;
    first_d    = first_q;
    last_d     = last_q;
    start_d    = start_q;
    lat_d      = lat_q;
    dvd_d      = dvd_q;
    rem_d      = rem_q;

    if (cmd_i.capture) begin
      start_d = 1'b0;
      lat_d   = '0;
    end

    if (cmd_i.exec) begin
      case (in_q.command)
        CMD_TICK: begin
          if (iv == '0) begin
            nd_d = '0;
          end else if (nd_q == '0) begin
            nd_d = in_q.now_ms + TIME_BITS'(iv);
          end else if (!due_diff[TIME_BITS-1]) begin
            if (in_q.mount_busy || in_q.poll_blocked || outst_q) begin
              deferred_d = deferred_q + COUNT_BITS'(1);
            end else begin
              lat_d = due_diff;
              if (due_diff > maxlat_q) begin
                maxlat_d = due_diff;
              end
              if (due_diff > TIME_BITS'(iv)) begin
                missed_d = missed_q + COUNT_BITS'(1);
              end
              started_d = started_q + COUNT_BITS'(1);
              outst_d   = 1'b1;
              oiv_d     = iv;
              start_d   = 1'b1;
            end
          end
        end
        CMD_DEMAND: begin
          ldt_d = in_q.now_ms;
          if ((nd_q == '0) || !in_q.position_valid) begin
            nd_d = in_q.now_ms;
          end
        end
        CMD_POLL_DONE: begin
          if (outst_q) begin
            outst_d = 1'b0;
            if (in_q.poll_ok) begin
              succ_d = succ_q + COUNT_BITS'(1);
              if (first_q == '0) begin
                first_d = in_q.now_ms;
              end
              last_d = in_q.now_ms;
              fail_d = '0;
            end else if (fail_q != '1) begin
              fail_d = fail_q + FAIL_BITS'(1);
            end
            if (oiv_q != '0) begin
              nd_d = nd_adv;
            end
            if (need_div) begin
              dvd_d = cu_diff;
              rem_d = '0;
            end
          end
        end
        CMD_RESET_SCHED: begin
          nd_d = '0;
        end
        CMD_RESET_FAIL: begin
          fail_d = '0;
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.div_step) begin
      rem_d = trial_ge ? trial_sub[IV_BITS-1:0] : trial[IV_BITS-1:0];
      dvd_d = {dvd_q[TIME_BITS-2:0], trial_ge};
    end

    // due = finish - rem + iv, missed += quotient + 1
    if (cmd_i.div_apply) begin
      nd_d     = in_q.now_ms - TIME_BITS'(rem_q) + TIME_BITS'(oiv_q);
      missed_d = missed_q + COUNT_BITS'(dvd_q) + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q      <= ACTIVE_RESET;
      idle_q     <= IDLE_RESET;
      win_q      <= WINDOW_RESET;
      ldt_q      <= '0;
      nd_q       <= '0;
      outst_q    <= 1'b0;
      oiv_q      <= '0;
      started_q  <= '0;
      deferred_q <= '0;
      missed_q   <= '0;
      succ_q     <= '0;
      maxlat_q   <= '0;
      fail_q     <= '0;
      first_q    <= '0;
      last_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ACTIVE: act_q  <= cfg_data_i;
          CFG_IDLE:   idle_q <= cfg_data_i;
          CFG_WINDOW: win_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end
      ldt_q      <= ldt_d;
      nd_q       <= nd_d;
      outst_q    <= outst_d;
      oiv_q      <= oiv_d;
      started_q  <= started_d;
      deferred_q <= deferred_d;
      missed_q   <= missed_d;
      succ_q     <= succ_d;
      maxlat_q   <= maxlat_d;
      fail_q     <= fail_d;
      first_q    <= first_d;
      last_q     <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_data_i;
    end
    start_q <= start_d;
    lat_q   <= lat_d;
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    if (cmd_i.publish) begin
      out_q.start_poll       <= start_q;
      out_q.latency_ms       <= lat_q;
      out_q.next_due_ms      <= nd_q;
      out_q.started_total    <= started_q;
      out_q.deferred_total   <= deferred_q;
      out_q.missed_total     <= missed_q;
      out_q.succeeded_total  <= succ_q;
      out_q.worst_latency_ms <= maxlat_q;
      out_q.failures_in_row  <= fail_q;
      out_q.first_success_ms <= first_q;
      out_q.last_success_ms  <= last_q;
      out_q.interval_used_ms <= iv;
    end
  end

  assign out_data_o = out_q;

endmodule

[rtl/pps_ctrl.sv]
module pps_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  pps_pkg::pps_sts_t  sts_i,
  output pps_pkg::pps_cmd_t  cmd_o
);
  import pps_pkg::*;
  `include "periodic_poll_scheduler_assert.svh"

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_APPLY,
    ST_PUBLISH
  } state_e;

  state_e                  state_q;
  logic [DIV_CNT_BITS-1:0] cnt_q;
  logic                    out_valid_q;
  logic                    out_free;
  logic                    accept;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) || ((state_q == ST_PUBLISH) && out_free);
  assign accept     = in_valid_i && in_ready_o;

  assign cmd_o.capture   = accept;
  assign cmd_o.exec      = (state_q == ST_EXEC);
  assign cmd_o.div_step  = (state_q == ST_DIV);
  assign cmd_o.div_apply = (state_q == ST_APPLY);
  assign cmd_o.publish   = (state_q == ST_PUBLISH) && out_free;

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (sts_i.need_div) begin
            state_q <= ST_DIV;
            cnt_q   <= '0;
          end else begin
            state_q <= ST_PUBLISH;
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + DIV_CNT_BITS'(1);
          if (cnt_q == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
            state_q <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          state_q <= ST_PUBLISH;
        end
        ST_PUBLISH: begin
          if (out_free) begin
            state_q <= accept ? ST_EXEC : ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `PPS_ASSERT_IMP(a_pub_free, cmd_o.publish, (!out_valid_q || out_ready_i), "publish over held result")
  `PPS_ASSERT_NXT(a_div_entry, (state_q == ST_EXEC && sts_i.need_div), (state_q == ST_DIV && cnt_q == '0), "divider entry broken")
  `PPS_ASSERT_IMP(a_busy_no_take, (state_q == ST_EXEC || state_q == ST_DIV || state_q == ST_APPLY), !in_ready_o, "transfer taken mid item")
  `PPS_ASSERT_NXT(a_valid_src, (!out_valid_q && !cmd_o.publish), !out_valid_q, "result valid without publish")

endmodule

[dv/tb_periodic_poll_scheduler.sv]
`timescale 1ns / 1ps

module tb_periodic_poll_scheduler;
  import pps_pkg::*;

  localparam logic [CMD_BITS-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_BITS-1:0] CMD_SPARE_LAST  = 3'd7;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam int SETTLE_CYCLES = 40;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [IV_BITS-1:0]      cfg_data_i;

  pps_in_if  in_if ();
  pps_out_if out_if ();

  periodic_poll_scheduler dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #2 clk_i = ~clk_i;

  // scheduler shadow state
  logic [IV_BITS-1:0]    fast_period = ACTIVE_RESET;
  logic [IV_BITS-1:0]    slow_period = IDLE_RESET;
  logic [IV_BITS-1:0]    demand_span = WINDOW_RESET;
  logic [TIME_BITS-1:0]  demand_stamp = '0;
  logic [TIME_BITS-1:0]  due_at = '0;
  logic                  busy_poll = 1'b0;
  logic [IV_BITS-1:0]    poll_period = '0;
  logic [COUNT_BITS-1:0] n_started = '0;
  logic [COUNT_BITS-1:0] n_deferred = '0;
  logic [COUNT_BITS-1:0] n_missed = '0;
  logic [COUNT_BITS-1:0] n_succeeded = '0;
  logic [TIME_BITS-1:0]  peak_latency = '0;
  logic [FAIL_BITS-1:0]  fail_streak = '0;
  logic [TIME_BITS-1:0]  first_ok_at = '0;
  logic [TIME_BITS-1:0]  last_ok_at = '0;

  pps_out_t             expected_reports[$];
  int                   mismatches = 0;
  int                   send_idle_pct = 0;
  int                   rcv_idle_pct = 0;
  int                   hold_req = 0;
  int                   hold_left = 0;
  logic [TIME_BITS-1:0] clock_ms = '0;

  function automatic logic [IV_BITS-1:0] period_for(logic [TIME_BITS-1:0] now, logic tv,
                                                    logic client);
    logic [TIME_BITS-1:0] since;
    since = now - demand_stamp;
    if (!tv) return '0;
    if ((demand_stamp != '0 && since < TIME_BITS'(demand_span)) || client) return fast_period;
    return slow_period;
  endfunction

  function automatic logic reached(logic [TIME_BITS-1:0] now, logic [TIME_BITS-1:0] due);
    logic [TIME_BITS-1:0] diff;
    diff = now - due;
    return !diff[TIME_BITS-1];
  endfunction

  function automatic pps_out_t predict_report(pps_in_t item);
    pps_out_t             res;
    logic [IV_BITS-1:0]   period;
    logic [TIME_BITS-1:0] late;
    logic [TIME_BITS-1:0] gap;
    logic [63:0]          slots;
    res = '0;
    late = '0;
    case (item.command)
      CMD_TICK: begin
        period = period_for(item.now_ms, item.time_valid, item.client_connected);
        if (period == '0) begin
          due_at = '0;
        end else if (due_at == '0) begin
          due_at = item.now_ms + TIME_BITS'(period);
        end else if (reached(item.now_ms, due_at)) begin
          if (item.mount_busy || item.poll_blocked || busy_poll) begin
            n_deferred++;
          end else begin
            late = item.now_ms - due_at;
            if (late > peak_latency) peak_latency = late;
            if (late > TIME_BITS'(period)) n_missed++;
            n_started++;
            busy_poll = 1'b1;
            poll_period = period;
            res.start_poll = 1'b1;
          end
        end
      end
      CMD_DEMAND: begin
        demand_stamp = item.now_ms;
        if (due_at == '0 || !item.position_valid) due_at = item.now_ms;
      end
      CMD_POLL_DONE: begin
        if (busy_poll) begin
          busy_poll = 1'b0;
          if (item.poll_ok) begin
            n_succeeded++;
            if (first_ok_at == '0) first_ok_at = item.now_ms;
            last_ok_at = item.now_ms;
            fail_streak = '0;
          end else if (fail_streak != '1) begin
            fail_streak++;
          end
          if (poll_period != '0) begin
            // advance by one period, then skip every slot already passed
            due_at = due_at + TIME_BITS'(poll_period);
            gap = item.now_ms - due_at;
            if (!gap[TIME_BITS-1]) begin
              slots = 64'(gap) / 64'(poll_period) + 64'd1;
              due_at = due_at + TIME_BITS'(slots * 64'(poll_period));
              n_missed = n_missed + COUNT_BITS'(slots);
            end
          end
        end
      end
      CMD_RESET_SCHED: due_at = '0;
      CMD_RESET_FAIL:  fail_streak = '0;
      default: ;
    endcase
    res.latency_ms       = late;
    res.next_due_ms      = due_at;
    res.started_total    = n_started;
    res.deferred_total   = n_deferred;
    res.missed_total     = n_missed;
    res.succeeded_total  = n_succeeded;
    res.worst_latency_ms = peak_latency;
    res.failures_in_row  = fail_streak;
    res.first_success_ms = first_ok_at;
    res.last_success_ms  = last_ok_at;
    res.interval_used_ms = period_for(item.now_ms, item.time_valid, item.client_connected);
    return res;
  endfunction

  function automatic void check_field(string name, logic [TIME_BITS-1:0] want,
                                      logic [TIME_BITS-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endfunction

  function automatic void compare_report(pps_out_t want, pps_out_t got);
    check_field("start_poll", TIME_BITS'(want.start_poll), TIME_BITS'(got.start_poll));
    check_field("latency_ms", want.latency_ms, got.latency_ms);
    check_field("next_due_ms", want.next_due_ms, got.next_due_ms);
    check_field("started_total", want.started_total, got.started_total);
    check_field("deferred_total", want.deferred_total, got.deferred_total);
    check_field("missed_total", want.missed_total, got.missed_total);
    check_field("succeeded_total", want.succeeded_total, got.succeeded_total);
    check_field("worst_latency_ms", want.worst_latency_ms, got.worst_latency_ms);
    check_field("failures_in_row", TIME_BITS'(want.failures_in_row),
                TIME_BITS'(got.failures_in_row));
    check_field("first_success_ms", want.first_success_ms, got.first_success_ms);
    check_field("last_success_ms", want.last_success_ms, got.last_success_ms);
    check_field("interval_used_ms", TIME_BITS'(want.interval_used_ms),
                TIME_BITS'(got.interval_used_ms));
  endfunction

  function automatic pps_in_t make_item(logic [CMD_BITS-1:0] cmd, logic [TIME_BITS-1:0] now,
                                        logic tv, logic client, logic busy, logic blocked,
                                        logic posv, logic ok);
    pps_in_t item;
    item.command          = cmd;
    item.now_ms           = now;
    item.time_valid       = tv;
    item.client_connected = client;
    item.mount_busy       = busy;
    item.poll_blocked     = blocked;
    item.position_valid   = posv;
    item.poll_ok          = ok;
    return item;
  endfunction

  task automatic send_item(input pps_in_t item);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= item;
    do @(posedge clk_i); while (!in_if.ready);
    expected_reports.push_back(predict_report(item));
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [IV_BITS-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_ACTIVE: fast_period = value;
      CFG_IDLE:   slow_period = value;
      CFG_WINDOW: demand_span = value;
      default: ;
    endcase
  endtask

  task automatic set_periods(input logic [IV_BITS-1:0] active, input logic [IV_BITS-1:0] idle,
                             input logic [IV_BITS-1:0] window);
    write_reg(CFG_ACTIVE, active);
    write_reg(CFG_IDLE, idle);
    write_reg(CFG_WINDOW, window);
  endtask

  // chain: back-to-back tick/poll-done pairs with no failure reset
  task automatic run_traffic(input int count, input int ok_pct, input int unsigned step_max,
                             input bit chain);
    pps_in_t             item;
    int                  roll;
    logic [CMD_BITS-1:0] cmd;
    repeat (count) begin
      roll = $urandom_range(99);
      if (busy_poll && roll < (chain ? 85 : 55)) begin
        clock_ms += $urandom_range(4 * step_max);
        cmd = CMD_POLL_DONE;
      end else begin
        clock_ms += $urandom_range(step_max);
        roll = $urandom_range(99);
        if (chain || roll < 60) cmd = CMD_TICK;
        else if (roll < 72) cmd = CMD_DEMAND;
        else if (roll < 77) cmd = CMD_POLL_DONE;
        else if (roll < 81) cmd = CMD_RESET_SCHED;
        else if (roll < 85) cmd = CMD_RESET_FAIL;
        else if (roll < 88) cmd = CMD_BITS'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
        else cmd = CMD_TICK;
      end
      item = make_item(cmd, clock_ms,
                       $urandom_range(99) < (chain ? 99 : 92),
                       $urandom_range(99) < 30,
                       $urandom_range(99) < (chain ? 4 : 15),
                       $urandom_range(99) < (chain ? 4 : 10),
                       $urandom_range(99) < 70,
                       $urandom_range(99) < ok_pct);
      if (!chain && $urandom_range(99) < 7) begin
        item.command = CMD_BITS'($urandom);
        item.now_ms  = $urandom;
        {item.time_valid, item.client_connected, item.mount_busy, item.poll_blocked,
         item.position_valid, item.poll_ok} = 6'($urandom);
      end
      send_item(item);
    end
  endtask

  task automatic test_directed_events();
    send_item(make_item(CMD_TICK, 32'd123, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
    send_item(make_item(CMD_SPARE_FIRST, TIME_MAX, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    send_item(make_item(CMD_SPARE_FIRST + 3'd1, TIME_MAX, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
                        1'b1));
    send_item(make_item(CMD_SPARE_LAST, TIME_MAX, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    // poll done with nothing outstanding
    send_item(make_item(CMD_POLL_DONE, 32'd200, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
    // demand at time zero reads as no demand
    send_item(make_item(CMD_DEMAND, 32'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    // armed due time wraps to zero
    send_item(make_item(CMD_TICK, TIME_MAX - 32'd4999, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(CMD_TICK, 32'd100, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(CMD_TICK, 32'd5100, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
    send_item(make_item(CMD_TICK, 32'd5200, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
    // late start, then a due tick while outstanding
    send_item(make_item(CMD_TICK, 32'd11100, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(CMD_TICK, 32'd11200, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(CMD_POLL_DONE, 32'd20110, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
    send_item(make_item(CMD_DEMAND, 32'd30000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(CMD_TICK, 32'd30500, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(CMD_POLL_DONE, 32'd30600, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(CMD_RESET_FAIL, 32'd30700, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(CMD_DEMAND, 32'd31000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(CMD_RESET_SCHED, 32'd31100, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(CMD_TICK, TIME_MAX, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    send_item(make_item(CMD_TICK, 32'd999, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1));
    send_item(make_item(CMD_POLL_DONE, 32'd999, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1));
    send_item(make_item(CMD_TICK, 32'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    drain();
  endtask

  task automatic test_fast_catch_up();
    set_periods(16'd1, 16'd7, 16'd50);
    clock_ms = 32'd5;
    run_traffic(250, 70, 12, 1'b0);
    drain();
  endtask

  task automatic test_wrap_and_disable();
    set_periods('1, '0, '0);
    clock_ms = 32'hFFF0_0000;
    run_traffic(200, 50, 40000, 1'b0);
    drain();
  endtask

  task automatic test_failure_streak();
    set_periods(16'd2, 16'd3, '1);
    clock_ms = 32'd1000;
    hold_req = 400;
    run_traffic(600, 0, 10, 1'b1);
    drain();
  endtask

  task automatic test_noise_mix();
    set_periods('0, '1, 16'd40000);
    clock_ms = 32'h7FFF_0000;
    run_traffic(100, 60, 50000, 1'b0);
    drain();
  endtask

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        if (expected_reports.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transfer, expected none, got %h", $time, out_if.data);
        end else begin
          compare_report(expected_reports.pop_front(), out_if.data);
        end
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  initial begin
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_ACTIVE;
    cfg_data_i  <= '0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 18;
    rcv_idle_pct  = 77;
    test_directed_events();
    test_fast_catch_up();
    send_idle_pct = 77;
    rcv_idle_pct  = 18;
    test_wrap_and_disable();
    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    test_failure_streak();
    test_noise_mix();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
